// ----- rtl/gpu_buffer_region_table_top_assert.svh -----
// Assertion macros shared by the region table RTL.
// Both sample on the rising edge of clk_i and are off while rst_ni is low.
`ifndef GPU_BUFFER_REGION_TABLE_TOP_ASSERT_SVH
`define GPU_BUFFER_REGION_TABLE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBRT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("region table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GBRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("region table assertion failed");

`endif

// ----- rtl/gbrt_pkg.sv -----
package gbrt_pkg;

  // Fixed field widths.
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned IDX_IN_W    = 16;
  localparam int unsigned ID_W        = 6;
  localparam int unsigned STATUS_W    = 4;
  localparam int unsigned MAX_REGIONS_DEF = 64;

  // A dword is four bytes.
  localparam int unsigned DWORD_SHIFT = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_REGISTER       = 2'd0,
    KIND_RESOLVE_BYTES  = 2'd1,
    KIND_RESOLVE_DWORDS = 2'd2,
    KIND_READ           = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 4'd0,
    ST_ZERO     = 4'd1,
    ST_OVERFLOW = 4'd2,
    ST_OVERLAP  = 4'd3,
    ST_FULL     = 4'd4,
    ST_PARTIAL  = 4'd5,
    ST_UNMAPPED = 4'd6,
    ST_PAYLOAD  = 4'd7,
    ST_NO_ENTRY = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_SETUP,
    CS_SCAN,
    CS_READ,
    CS_OUT
  } ctrl_state_e;

  // One stored region: base, size and the precomputed end (base + size).
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] lim;
  } region_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic setup;
    logic scan;
    logic read_fin;
    logic load_out;
  } gbrt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;
    logic need_read;
    logic scan_stop;
    logic out_free;
  } gbrt_stat_t;

endpackage

// ----- rtl/gbrt_ctrl.sv -----
module gbrt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gbrt_pkg::gbrt_stat_t stat_i,
  output gbrt_pkg::gbrt_cmd_t  cmd_o
);
  import gbrt_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: begin
        if (in_valid_i) begin
          state_d = CS_SETUP;
        end
      end
      CS_SETUP: begin
        priority if (stat_i.need_scan) begin
          state_d = CS_SCAN;
        end else if (stat_i.need_read) begin
          state_d = CS_READ;
        end else begin
          state_d = CS_OUT;
        end
      end
      CS_SCAN: begin
        if (stat_i.scan_stop) begin
          state_d = CS_OUT;
        end
      end
      CS_READ: begin
        state_d = CS_OUT;
      end
      CS_OUT: begin
        if (stat_i.out_free) begin
          state_d = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  // Outputs: one command per state, the item enters only in idle.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      CS_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      CS_SETUP: begin
        cmd_o.setup = 1'b1;
      end
      CS_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      CS_READ: begin
        cmd_o.read_fin = 1'b1;
      end
      CS_OUT: begin
        cmd_o.load_out = stat_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

// ----- rtl/gbrt_dpath.sv -----
`include "gpu_buffer_region_table_top_assert.svh"

module gbrt_dpath #(
  parameter int unsigned MAX_REGIONS = gbrt_pkg::MAX_REGIONS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gbrt_pkg::gbrt_cmd_t            cmd_i,
  output gbrt_pkg::gbrt_stat_t           stat_o,
  input  logic [gbrt_pkg::KIND_W-1:0]    kind_i,
  input  logic [gbrt_pkg::ADDR_W-1:0]    address_i,
  input  logic [gbrt_pkg::ADDR_W-1:0]    length_i,
  input  logic [gbrt_pkg::IDX_IN_W-1:0]  region_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [gbrt_pkg::STATUS_W-1:0]  status_o,
  output logic [gbrt_pkg::ID_W-1:0]      region_id_o,
  output logic [gbrt_pkg::ADDR_W-1:0]    start_offset_o,
  output logic [gbrt_pkg::ADDR_W-1:0]    total_bytes_o,
  output logic                           conflict_valid_o,
  output logic [gbrt_pkg::ID_W-1:0]      conflict_id_o,
  output logic [gbrt_pkg::ADDR_W-1:0]    entry_base_o,
  output logic [gbrt_pkg::ADDR_W-1:0]    entry_size_o
);
  import gbrt_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned IdxW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

  // Captured request.
  kind_e                 kind_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [ADDR_W-1:0]     cnt_q;
  logic                  pay_bad_q;
  logic [IDX_IN_W-1:0]   idx_q;
  logic [ADDR_W-1:0]     end_q;

  // Table state.
  region_t               mem_q [MAX_REGIONS];
  region_t               rd_q;
  logic [CntW-1:0]       count_q;
  logic [IdxW-1:0]       chk_q;
  logic [IdxW-1:0]       raddr;

  // Pending result and output register.
  status_e               res_status_q;
  logic [ID_W-1:0]       res_id_q;
  logic [ADDR_W-1:0]     res_offset_q;
  logic [ADDR_W-1:0]     res_bcount_q;
  logic                  res_cvalid_q;
  logic [ID_W-1:0]       res_cid_q;
  logic [ADDR_W-1:0]     res_base_q;
  logic [ADDR_W-1:0]     res_size_q;
  logic                  out_valid_q;
  status_e               out_status_q;
  logic [ID_W-1:0]       out_id_q;
  logic [ADDR_W-1:0]     out_offset_q;
  logic [ADDR_W-1:0]     out_bcount_q;
  logic                  out_cvalid_q;
  logic [ID_W-1:0]       out_cid_q;
  logic [ADDR_W-1:0]     out_base_q;
  logic [ADDR_W-1:0]     out_size_q;

  // Setup and scan decisions.
  logic [ADDR_W:0]       sum;
  logic                  zero;
  logic                  ovf;
  logic                  early_fail;
  logic                  range_ok;
  logic                  is_reg;
  logic                  ovl;
  logic                  contain;
  logic                  last;
  logic                  full;
  logic                  commit;
  logic [ADDR_W-1:0]     wlim;

  // Capture the item; dword counts are scaled to bytes here.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q    <= kind_e'(kind_i);
      addr_q    <= address_i;
      idx_q     <= region_index_i;
      pay_bad_q <= (kind_e'(kind_i) == KIND_RESOLVE_DWORDS) &&
                   (length_i[ADDR_W-1 -: DWORD_SHIFT] != '0);
      if (kind_e'(kind_i) == KIND_RESOLVE_DWORDS) begin
        cnt_q <= length_i << DWORD_SHIFT;
      end else begin
        cnt_q <= length_i;
      end
    end
  end

  // Range end, overflow and early outcomes.
  assign sum        = {1'b0, addr_q} + {1'b0, cnt_q};
  assign zero       = (cnt_q == '0);
  assign ovf        = sum[ADDR_W];
  assign is_reg     = (kind_q == KIND_REGISTER);
  assign early_fail = pay_bad_q || zero || ovf;
  assign range_ok   = (idx_q < IDX_IN_W'(count_q));
  assign full       = (count_q == CntW'(MAX_REGIONS));

  // Compare the request against the region read out last cycle.
  assign ovl     = (addr_q < rd_q.lim) && (rd_q.base < end_q);
  assign contain = (addr_q >= rd_q.base) && (end_q <= rd_q.lim);
  assign last    = ((CntW'(chk_q) + CntW'(1)) == count_q);

  assign stat_o.need_scan = (kind_q != KIND_READ) && !early_fail && (count_q != '0);
  assign stat_o.need_read = (kind_q == KIND_READ) && range_ok;
  assign stat_o.scan_stop = is_reg ? (ovl || last) : (contain || last);
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  // Append a region: straight from setup into an empty table, or after a clean scan.
  assign commit = (cmd_i.setup && is_reg && !zero && !ovf && (count_q == '0)) ||
                  (cmd_i.scan && is_reg && !ovl && last && !full);
  assign wlim   = cmd_i.setup ? sum[ADDR_W-1:0] : end_q;

  // Read address: the requested entry or the first one on setup, the next one while scanning.
  always_comb begin
    if (cmd_i.setup) begin
      raddr = (kind_q == KIND_READ) ? idx_q[IdxW-1:0] : '0;
    end else begin
      raddr = chk_q + IdxW'(1);
    end
  end

  // Region memory with registered read.
  always_ff @(posedge clk_i) begin
    if (commit) begin
      mem_q[count_q[IdxW-1:0]] <= '{base: addr_q, size: cnt_q, lim: wlim};
    end
    rd_q <= mem_q[raddr];
  end

  // Region count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (commit) begin
      count_q <= count_q + CntW'(1);
    end
  end

  // Scan index and latched range end.
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      chk_q <= '0;
      end_q <= sum[ADDR_W-1:0];
    end else if (cmd_i.scan) begin
      chk_q <= chk_q + IdxW'(1);
    end
  end

  // Build the result over setup, scan and read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      res_id_q     <= '0;
      res_offset_q <= '0;
      res_cvalid_q <= 1'b0;
      res_cid_q    <= '0;
      res_base_q   <= '0;
      res_size_q   <= '0;
      res_bcount_q <= (kind_q == KIND_REGISTER || kind_q == KIND_READ || pay_bad_q) ?
                      '0 : cnt_q;
      res_status_q <= ST_OK;
      if (kind_q == KIND_READ) begin
        if (!range_ok) begin
          res_status_q <= ST_NO_ENTRY;
        end
      end else begin
        priority if (pay_bad_q) begin
          res_status_q <= ST_PAYLOAD;
        end else if (zero) begin
          res_status_q <= ST_ZERO;
        end else if (ovf) begin
          res_status_q <= ST_OVERFLOW;
        end else if (count_q == '0) begin
          res_status_q <= is_reg ? ST_OK : ST_UNMAPPED;
        end
      end
    end else if (cmd_i.scan) begin
      if (is_reg) begin
        if (ovl) begin
          res_status_q <= ST_OVERLAP;
          res_cvalid_q <= 1'b1;
          res_cid_q    <= ID_W'(chk_q);
        end else if (last) begin
          res_status_q <= full ? ST_FULL : ST_OK;
          res_id_q     <= full ? '0 : ID_W'(count_q);
        end
      end else if (contain) begin
        res_status_q <= ST_OK;
        res_id_q     <= ID_W'(chk_q);
        res_offset_q <= addr_q - rd_q.base;
        res_cvalid_q <= 1'b0;
        res_cid_q    <= '0;
      end else begin
        // Remember the last region that only intersects the range.
        if (ovl) begin
          res_cvalid_q <= 1'b1;
          res_cid_q    <= ID_W'(chk_q);
        end
        if (last) begin
          res_status_q <= (ovl || res_cvalid_q) ? ST_PARTIAL : ST_UNMAPPED;
        end
      end
    end else if (cmd_i.read_fin) begin
      res_status_q <= ST_OK;
      res_id_q     <= ID_W'(idx_q);
      res_base_q   <= rd_q.base;
      res_size_q   <= rd_q.size;
    end
  end

  // Output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_offset_q <= res_offset_q;
      out_bcount_q <= res_bcount_q;
      out_cvalid_q <= res_cvalid_q;
      out_cid_q    <= res_cid_q;
      out_base_q   <= res_base_q;
      out_size_q   <= res_size_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign region_id_o      = out_id_q;
  assign start_offset_o   = out_offset_q;
  assign total_bytes_o    = out_bcount_q;
  assign conflict_valid_o = out_cvalid_q;
  assign conflict_id_o    = out_cid_q;
  assign entry_base_o     = out_base_q;
  assign entry_size_o     = out_size_q;

  // The table never holds more regions than it has entries.
  `GBRT_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CntW'(MAX_REGIONS))
  // An append only happens with room left, and the count then grows by one.
  `GBRT_ASSERT_IMPL(a_commit_room, commit, !full)
  `GBRT_ASSERT_NEXT(a_commit_step, commit, count_q == $past(count_q) + CntW'(1))
  // A conflict id is only reported with an overlap or a partial mapping.
  `GBRT_ASSERT_IMPL(a_conflict_status, out_valid_q && out_cvalid_q,
                    out_status_q == ST_OVERLAP || out_status_q == ST_PARTIAL)

endmodule

// ----- rtl/gpu_buffer_region_table_top.sv -----
// An accepted item goes through setup, then a table scan or an entry read where it needs one,
// and then into the output register; items that need neither go from setup straight to output.
// One item is handled at a time, and its scan walks the region memory one entry per cycle.
// Reset (rst_ni low, asynchronous) empties the table and drops any pending result.
module gpu_buffer_region_table_top #(
  parameter int unsigned MAX_REGIONS = gbrt_pkg::MAX_REGIONS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [gbrt_pkg::KIND_W-1:0]    kind_i,
  input  logic [gbrt_pkg::ADDR_W-1:0]    address_i,
  input  logic [gbrt_pkg::ADDR_W-1:0]    length_i,
  input  logic [gbrt_pkg::IDX_IN_W-1:0]  region_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [gbrt_pkg::STATUS_W-1:0]  status_o,
  output logic [gbrt_pkg::ID_W-1:0]      region_id_o,
  output logic [gbrt_pkg::ADDR_W-1:0]    start_offset_o,
  output logic [gbrt_pkg::ADDR_W-1:0]    total_bytes_o,
  output logic                           conflict_valid_o,
  output logic [gbrt_pkg::ID_W-1:0]      conflict_id_o,
  output logic [gbrt_pkg::ADDR_W-1:0]    entry_base_o,
  output logic [gbrt_pkg::ADDR_W-1:0]    entry_size_o
);
  import gbrt_pkg::*;

  gbrt_cmd_t  cmd;
  gbrt_stat_t stat;

  // Sequencer.
  gbrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Region table, comparators and result registers.
  gbrt_dpath #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .kind_i           (kind_i),
    .address_i        (address_i),
    .length_i         (length_i),
    .region_index_i   (region_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .region_id_o      (region_id_o),
    .start_offset_o   (start_offset_o),
    .total_bytes_o    (total_bytes_o),
    .conflict_valid_o (conflict_valid_o),
    .conflict_id_o    (conflict_id_o),
    .entry_base_o     (entry_base_o),
    .entry_size_o     (entry_size_o)
  );

endmodule
